// ===== hdl/dpjs_pkg.sv =====
package dpjs_pkg;

  localparam int ELEM_W   = 32;
  localparam int DOT_W    = 2 * ELEM_W;
  localparam int NORM_W   = 64;
  localparam int LEN_W    = 13;
  localparam int FIX_W    = 17;
  localparam int BYTE_W   = 8;
  localparam int FRAC_SH  = 16;

  localparam int SUM_W    = NORM_W + 1;
  localparam int NUM_W    = DOT_W + FRAC_SH;
  localparam int SL_W     = SUM_W + LEN_W;
  localparam int Q20_W    = DOT_W + 5;
  localparam int THR_W    = Q20_W + FRAC_SH;
  localparam int RB_W     = SL_W + BYTE_W;
  localparam int DSH_W    = SL_W + BYTE_W - 1;
  localparam int CNT_W    = $clog2(DOT_W);

  localparam int QDEPTH   = 2;
  localparam int PTR_W    = $clog2(QDEPTH);
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

  localparam logic [FIX_W-1:0]  FIX_ONE  = FIX_W'(1 << FRAC_SH);
  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [NORM_W-1:0] norm_a;
    logic [NORM_W-1:0] norm_b;
  } job_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_QDIV,
    B_THR,
    B_MUL,
    B_CHK,
    B_FRAC,
    B_FRND,
    B_BYTE,
    B_BRND,
    B_DONE
  } back_state_t;

endpackage

// ===== hdl/dpjs_front.sv =====
module dpjs_front
  import dpjs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  input  logic [NORM_W-1:0]        norm_sq_a,
  input  logic [NORM_W-1:0]        norm_sq_b,
  input  logic                     same_vector,
  input  logic                     last,
  input  q_status_t                q_stat,
  output logic                     enq,
  output job_t                     enq_job
);

  logic                    s1_valid;
  logic                    s1_last;
  logic                    s1_same;
  logic signed [DOT_W-1:0] s1_prod;
  logic [NORM_W-1:0]       s1_na;
  logic [NORM_W-1:0]       s1_nb;
  logic [DOT_W-1:0]        acc;
  logic [DOT_W-1:0]        dot_sum;
  logic [QLVL_W:0]         fill;
  logic                    accept;

  // count a last item still in the product stage as already queued
  assign fill   = {1'b0, q_stat.level} + {{QLVL_W{1'b0}}, s1_valid & s1_last};
  assign full   = fill >= (QLVL_W + 1)'(QDEPTH);
  assign accept = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod <= elem_a * elem_b;
      s1_last <= last;
      s1_same <= same_vector;
      s1_na   <= norm_sq_a;
      s1_nb   <= norm_sq_b;
    end
  end

  assign dot_sum = acc + s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_valid) begin
      acc <= s1_last ? '0 : dot_sum;
    end
  end

  assign enq     = s1_valid & s1_last & ~s1_same;
  assign enq_job = '{dot: dot_sum, norm_a: s1_na, norm_b: s1_nb};

endmodule

// ===== hdl/dpjs_queue.sv =====
module dpjs_queue
  import dpjs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      enq,
  input  job_t      enq_job,
  input  logic      deq,
  output job_t      deq_job,
  output q_status_t q_stat
);

  job_t              mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QLVL_W-1:0] level;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= enq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (deq) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      level <= level + QLVL_W'(enq) - QLVL_W'(deq);
    end
  end

  assign deq_job = mem[rd_ptr];
  assign q_stat  = '{empty: (level == '0), level: level};

endmodule

// ===== hdl/dpjs_back.sv =====
module dpjs_back
  import dpjs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [LEN_W-1:0]  len,
  input  q_status_t         q_stat,
  input  job_t              deq_job,
  output logic              deq,
  input  logic              pop,
  output logic              empty,
  output logic              exists,
  output logic [FIX_W-1:0]  jaccard_fixed,
  output logic [BYTE_W-1:0] jaccard_byte
);

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [DOT_W-1:0]  mag;
  logic [DOT_W-1:0]  dvd;
  logic [LEN_W-1:0]  rem;
  logic [SUM_W-1:0]  sum;
  logic [SL_W-1:0]   mcand;
  logic [LEN_W-1:0]  mlen;
  logic [SL_W-1:0]   sl;
  logic [SL_W-1:0]   den;
  logic [SL_W-1:0]   fr;
  logic [FRAC_SH-1:0] fq;
  logic [RB_W-1:0]   rb;
  logic [DSH_W-1:0]  dsh;
  logic [BYTE_W-1:0] bq;
  logic              res_exists;
  logic [FIX_W-1:0]  res_fixed;
  logic [BYTE_W-1:0] res_byte;
  logic              out_valid;
  logic              out_load;

  logic [DOT_W-1:0]  mag_c;
  logic [LEN_W:0]    t_div;
  logic              div_ge;
  logic [LEN_W:0]    t_div_sub;
  logic [Q20_W-1:0]  q20;
  logic [THR_W-1:0]  thr;
  logic              exists_c;
  logic [NUM_W-1:0]  num;
  logic              sat_c;
  logic [SL_W-1:0]   den_c;
  logic [SL_W:0]     fr_t;
  logic              fr_ge;
  logic [SL_W:0]     fr_sub;
  logic [RB_W-1:0]   nb;
  logic [RB_W-1:0]   rb_init;
  logic              rb_ge;
  logic [RB_W-1:0]   rb_sub;
  logic              byte_round;

  assign mag_c = deq_job.dot[DOT_W-1] ? (~deq_job.dot + 1'b1) : deq_job.dot;

  // one quotient bit of |dot| / len per cycle
  assign t_div     = {rem, dvd[DOT_W-1]};
  assign div_ge    = t_div >= {1'b0, len};
  assign t_div_sub = t_div - {1'b0, len};

  // threshold: q * 20 in Q.16 against the norm sum
  assign q20      = ({{(Q20_W-DOT_W){1'b0}}, dvd} << 4)
                  + ({{(Q20_W-DOT_W){1'b0}}, dvd} << 2);
  assign thr      = {q20, {FRAC_SH{1'b0}}};
  assign exists_c = ~neg && (dvd != '0) && ({{(THR_W-SUM_W){1'b0}}, sum} < thr);

  assign num   = {mag, {FRAC_SH{1'b0}}};
  // denominator not positive, or num >= den: clamp to one
  assign sat_c = (num >= {{(NUM_W-SL_W){1'b0}}, sl})
              || ({num, 1'b0} >= {{(NUM_W+1-SL_W){1'b0}}, sl});
  assign den_c = sl - num[SL_W-1:0];

  assign fr_t   = {fr, 1'b0};
  assign fr_ge  = fr_t >= {1'b0, den};
  assign fr_sub = fr_t - {1'b0, den};

  assign nb      = {{(RB_W-SL_W){1'b0}}, fr};
  assign rb_init = (nb << BYTE_W) - nb;
  assign rb_ge   = rb >= {1'b0, dsh};
  assign rb_sub  = rb - {1'b0, dsh};

  assign byte_round = {rb[SL_W-1:0], 1'b0} >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    deq        = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          deq        = 1'b1;
          state_next = B_QDIV;
        end
      end
      B_QDIV: begin
        if (cnt == '0) begin
          state_next = B_THR;
        end
      end
      B_THR: begin
        state_next = exists_c ? B_MUL : B_DONE;
      end
      B_MUL: begin
        if (cnt == '0) begin
          state_next = B_CHK;
        end
      end
      B_CHK: begin
        state_next = sat_c ? B_DONE : B_FRAC;
      end
      B_FRAC: begin
        if (cnt == '0) begin
          state_next = B_FRND;
        end
      end
      B_FRND: begin
        state_next = B_BYTE;
      end
      B_BYTE: begin
        if (cnt == '0) begin
          state_next = B_BRND;
        end
      end
      B_BRND: begin
        state_next = B_DONE;
      end
      B_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (deq) begin
          neg <= deq_job.dot[DOT_W-1];
          mag <= mag_c;
          dvd <= mag_c;
          rem <= '0;
          sum <= {1'b0, deq_job.norm_a} + {1'b0, deq_job.norm_b};
          cnt <= CNT_W'(DOT_W - 1);
        end
      end
      B_QDIV: begin
        rem <= div_ge ? t_div_sub[LEN_W-1:0] : t_div[LEN_W-1:0];
        dvd <= {dvd[DOT_W-2:0], div_ge};
        cnt <= cnt - 1'b1;
      end
      B_THR: begin
        res_exists <= exists_c;
        res_fixed  <= '0;
        res_byte   <= '0;
        sl         <= '0;
        mcand      <= {{(SL_W-SUM_W){1'b0}}, sum};
        mlen       <= len;
        cnt        <= CNT_W'(LEN_W - 1);
      end
      B_MUL: begin
        if (mlen[0]) begin
          sl <= sl + mcand;
        end
        mcand <= mcand << 1;
        mlen  <= mlen >> 1;
        cnt   <= cnt - 1'b1;
      end
      B_CHK: begin
        if (sat_c) begin
          res_fixed <= FIX_ONE;
          res_byte  <= BYTE_MAX;
        end
        den <= den_c;
        fr  <= num[SL_W-1:0];
        fq  <= '0;
        cnt <= CNT_W'(FRAC_SH - 1);
      end
      B_FRAC: begin
        fr  <= fr_ge ? fr_sub[SL_W-1:0] : fr_t[SL_W-1:0];
        fq  <= {fq[FRAC_SH-2:0], fr_ge};
        cnt <= cnt - 1'b1;
      end
      B_FRND: begin
        // round half up from the leftover remainder, then start 255 * J
        res_fixed <= {1'b0, fq} + FIX_W'(fr_ge);
        fr        <= num[SL_W-1:0];
        rb        <= '0;
        dsh       <= {den, {(BYTE_W-1){1'b0}}};
        bq        <= '0;
        cnt       <= CNT_W'(BYTE_W);
      end
      B_BYTE: begin
        if (cnt == CNT_W'(BYTE_W)) begin
          rb <= rb_init;
        end else begin
          if (rb_ge) begin
            rb <= rb_sub;
          end
          bq  <= {bq[BYTE_W-2:0], rb_ge};
          dsh <= dsh >> 1;
        end
        cnt <= cnt - 1'b1;
      end
      B_BRND: begin
        // round half up from the leftover remainder
        res_byte <= bq + BYTE_W'(byte_round);
      end
      B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      exists        <= res_exists;
      jaccard_fixed <= res_fixed;
      jaccard_byte  <= res_byte;
    end
  end

  assign empty = ~out_valid;

endmodule

// ===== hdl/dot_product_jaccard_scorer.sv =====
// Channel   Handshake             Payload
// config    cfg_valid/cfg_ready   vector_length
// input     push/full             elem_a, elem_b, norm_sq_a, norm_sq_b, same_vector, last
// result    empty/pop             exists, jaccard_fixed, jaccard_byte
//
// Elements are taken one per cycle while not full; the product is registered, then added to the sum.
// A scored pair waits in a two-entry job queue. Scoring divides |dot| by the length, stops
// if the pair does not exist, multiplies the norm sum by the length, stops if J clamps to
// one, and else runs the fraction and byte ratio loops; the result then may wait on pop.
// Input stalls only when the job queue and the product stage hold two pairs.
// Reset clears the accumulator and the queue and empties the result register; length is 1.
module dot_product_jaccard_scorer
  import dpjs_pkg::*;
#(
  parameter int MAX_LENGTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LEN_W-1:0]         vector_length,
  input  logic                     push,
  output logic                     full,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  input  logic [NORM_W-1:0]        norm_sq_a,
  input  logic [NORM_W-1:0]        norm_sq_b,
  input  logic                     same_vector,
  input  logic                     last,
  output logic                     empty,
  input  logic                     pop,
  output logic                     exists,
  output logic [FIX_W-1:0]         jaccard_fixed,
  output logic [BYTE_W-1:0]        jaccard_byte
);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_clamp;
  logic             enq;
  job_t             enq_job;
  logic             deq;
  job_t             deq_job;
  q_status_t        q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (vector_length == '0) begin
      len_clamp = LEN_W'(1);
    end else if (32'(vector_length) > MAX_LENGTH) begin
      len_clamp = LEN_W'(MAX_LENGTH);
    end else begin
      len_clamp = vector_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(1);
    end else if (cfg_valid) begin
      len <= len_clamp;
    end
  end

  dpjs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .elem_a      (elem_a),
    .elem_b      (elem_b),
    .norm_sq_a   (norm_sq_a),
    .norm_sq_b   (norm_sq_b),
    .same_vector (same_vector),
    .last        (last),
    .q_stat      (q_stat),
    .enq         (enq),
    .enq_job     (enq_job)
  );

  dpjs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_job (enq_job),
    .deq     (deq),
    .deq_job (deq_job),
    .q_stat  (q_stat)
  );

  dpjs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .len           (len),
    .q_stat        (q_stat),
    .deq_job       (deq_job),
    .deq           (deq),
    .pop           (pop),
    .empty         (empty),
    .exists        (exists),
    .jaccard_fixed (jaccard_fixed),
    .jaccard_byte  (jaccard_byte)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> (q_stat.level < QLVL_W'(QDEPTH)))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    deq |-> !q_stat.empty)
    else $error("job queue read while empty");

  a_zero_absent: assert property (@(posedge clk) disable iff (rst)
    (!empty && !exists) |-> (jaccard_fixed == '0 && jaccard_byte == '0))
    else $error("nonzero score on a pair that does not exist");

  a_one_is_max: assert property (@(posedge clk) disable iff (rst)
    (!empty && jaccard_fixed == FIX_ONE) |-> (jaccard_byte == BYTE_MAX))
    else $error("byte score disagrees with a ratio of one");

endmodule
